// ===== src/k_smallest_max_heap_unit_defines.svh =====
`ifndef K_SMALLEST_MAX_HEAP_UNIT_DEFINES_SVH
`define K_SMALLEST_MAX_HEAP_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define KSMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define KSMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ksmh_pkg.sv =====
package ksmh_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int K_W             = 7;
  localparam int DATA_W          = 32;
  localparam logic [K_W-1:0] K_RESET = 7'd64;

  typedef struct packed {
    logic cap;
    logic append;
    logic reject;
    logic sift_init;
    logic heap_ld;
    logic heap_get;
    logic sift_move;
    logic sift_end;
  } ksmh_cmd_t;

  typedef struct packed {
    logic fill_lt_k;
    logic fill_last;
    logic heap_start;
    logic gt_root;
    logic move;
    logic heap_more;
  } ksmh_stat_t;

endpackage

// ===== src/ksmh_ctrl.sv =====
module ksmh_ctrl import ksmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ksmh_stat_t stat,
  output ksmh_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HEAP_LD,
    S_HEAP_GET,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.fill_lt_k) begin
          cmd.append = 1'b1;
          if (stat.fill_last && stat.heap_start) begin
            state_nxt = S_HEAP_LD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.gt_root) begin
          cmd.reject = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.sift_init = 1'b1;
          state_nxt     = S_SIFT_RD;
        end
      end
      S_HEAP_LD: begin
        cmd.heap_ld = 1'b1;
        state_nxt   = S_HEAP_GET;
      end
      S_HEAP_GET: begin
        cmd.heap_get = 1'b1;
        state_nxt    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        if (stat.move) begin
          cmd.sift_move = 1'b1;
          state_nxt     = S_SIFT_RD;
        end else begin
          cmd.sift_end = 1'b1;
          state_nxt    = stat.heap_more ? S_HEAP_LD : S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== src/ksmh_dp.sv =====
module ksmh_dp import ksmh_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [K_W-1:0]    cfg_wdata,
  input  logic              in_restart,
  input  logic [DATA_W-1:0] in_cand_key,
  input  logic [DATA_W-1:0] in_cand_value,
  input  ksmh_cmd_t         cmd,
  output ksmh_stat_t        stat,
  output logic              out_accepted,
  output logic              out_is_full,
  output logic [DATA_W-1:0] out_max_key,
  output logic [DATA_W-1:0] out_max_value
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int FW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (FW > K_W) ? FW : K_W;
  localparam int PW = AW + 2;

  logic [DATA_W-1:0] key_mem [MAX_ENTRIES];
  logic [DATA_W-1:0] val_mem [MAX_ENTRIES];

  logic [K_W-1:0]    k_r;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] key_r, val_r;
  logic [DATA_W-1:0] root_key_r, root_val_r;
  logic              acc_r;
  logic [DATA_W-1:0] rd_a_key_r, rd_a_val_r, rd_b_key_r, rd_b_val_r;

  logic [CW-1:0]     k_ext, k_max;
  logic [FW-1:0]     keff, fill_inc;
  logic [PW-1:0]     keff_p, l_pos, r_pos;
  logic [AW-1:0]     idx_dec, raddr_a, raddr_b, waddr, big_pos;
  logic              l_gt, r_gt, we;
  logic [DATA_W-1:0] cur_key, child_key, child_val, wkey, wval;

  assign k_ext = CW'(k_r);
  assign k_max = CW'(MAX_ENTRIES);
  assign keff  = (k_ext == '0) ? FW'(1) :
                 (k_ext > k_max) ? FW'(MAX_ENTRIES) : FW'(k_ext);
  assign keff_p   = PW'(keff);
  assign fill_inc = fill_r + FW'(1);

  assign l_pos   = {1'b0, pos_r, 1'b1};
  assign r_pos   = l_pos + PW'(1);
  assign idx_dec = idx_r - AW'(1);

  // pick the larger child; left wins on a tie
  assign l_gt      = (l_pos < keff_p) && (rd_a_key_r > key_r);
  assign cur_key   = l_gt ? rd_a_key_r : key_r;
  assign r_gt      = (r_pos < keff_p) && (rd_b_key_r > cur_key);
  assign child_key = r_gt ? rd_b_key_r : rd_a_key_r;
  assign child_val = r_gt ? rd_b_val_r : rd_a_val_r;
  assign big_pos   = r_gt ? r_pos[AW-1:0] : l_pos[AW-1:0];

  assign stat.fill_lt_k  = (fill_r < keff);
  assign stat.fill_last  = (fill_inc == keff);
  assign stat.heap_start = ((keff >> 1) != '0);
  assign stat.gt_root    = (key_r > root_key_r);
  assign stat.move       = l_gt || r_gt;
  assign stat.heap_more  = (idx_r != '0);

  assign raddr_a = cmd.heap_ld ? idx_dec : l_pos[AW-1:0];
  assign raddr_b = r_pos[AW-1:0];

  assign we    = cmd.append || cmd.sift_move || cmd.sift_end;
  assign waddr = cmd.append ? fill_r[AW-1:0] : pos_r;
  assign wkey  = cmd.sift_move ? child_key : key_r;
  assign wval  = cmd.sift_move ? child_val : val_r;

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_we) begin
      fill_nxt = '0;
    end else if (cmd.cap && (in_restart || (fill_r > keff))) begin
      fill_nxt = '0;
    end else if (cmd.append) begin
      fill_nxt = fill_inc;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.cap) begin
      idx_nxt = '0;
    end else if (cmd.append && stat.fill_last) begin
      idx_nxt = AW'(keff >> 1);
    end else if (cmd.heap_ld) begin
      idx_nxt = idx_dec;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.sift_init) begin
      pos_nxt = '0;
    end else if (cmd.heap_get) begin
      pos_nxt = idx_r;
    end else if (cmd.sift_move) begin
      pos_nxt = big_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= K_RESET;
      fill_r <= '0;
      idx_r  <= '0;
      pos_r  <= '0;
      acc_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
      pos_r  <= pos_nxt;
      if (cmd.cap) begin
        acc_r <= 1'b1;
      end else if (cmd.reject) begin
        acc_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      key_r <= in_cand_key;
      val_r <= in_cand_value;
    end else if (cmd.heap_get) begin
      key_r <= rd_a_key_r;
      val_r <= rd_a_val_r;
    end
    if (we && (waddr == '0)) begin
      root_key_r <= wkey;
      root_val_r <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
    rd_a_key_r <= key_mem[raddr_a];
    rd_a_val_r <= val_mem[raddr_a];
    rd_b_key_r <= key_mem[raddr_b];
    rd_b_val_r <= val_mem[raddr_b];
  end

  assign out_accepted  = acc_r;
  assign out_is_full   = (fill_r == keff);
  assign out_max_key   = out_is_full ? root_key_r : '0;
  assign out_max_value = out_is_full ? root_val_r : '0;

endmodule

// ===== src/k_smallest_max_heap_unit.sv =====
// Channel   Handshake           Payload
// request   start / busy        in_restart, in_cand_key, in_cand_value
// result    out_valid (strobe)  out_accepted, out_is_full, out_max_key, out_max_value
// config    cfg_we              cfg_wdata (K)
//
// A request is taken when start is high and busy is low; one request is worked at a time.
// Append below K and reject of a key above the root: S_DECIDE, then S_DONE.
// Replace root: S_DECIDE, then S_SIFT_RD and S_SIFT_CMP per heap level visited, then S_DONE.
// K-th request heapifies: K/2 nodes, each through S_HEAP_LD and S_HEAP_GET, then sifted level by level.
// Reset (rst_n low, synchronous) empties the store and sets K to 64; results cannot be stalled.
module k_smallest_max_heap_unit import ksmh_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_restart,
  input  logic [DATA_W-1:0] in_cand_key,
  input  logic [DATA_W-1:0] in_cand_value,
  output logic              out_valid,
  output logic              out_accepted,
  output logic              out_is_full,
  output logic [DATA_W-1:0] out_max_key,
  output logic [DATA_W-1:0] out_max_value,
  input  logic              cfg_we,
  input  logic [K_W-1:0]    cfg_wdata
);

  ksmh_cmd_t  cmd;
  ksmh_stat_t stat;

  ksmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ksmh_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_restart    (in_restart),
    .in_cand_key   (in_cand_key),
    .in_cand_value (in_cand_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_accepted  (out_accepted),
    .out_is_full   (out_is_full),
    .out_max_key   (out_max_key),
    .out_max_value (out_max_value)
  );

endmodule

// ===== src/ksmh_checker.sv =====
`include "k_smallest_max_heap_unit_defines.svh"

module ksmh_checker import ksmh_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic              out_accepted,
  input logic              out_is_full,
  input logic [DATA_W-1:0] out_max_key,
  input logic [DATA_W-1:0] out_max_value
);

  logic root_clear;

  assign root_clear = (out_max_key == '0) && (out_max_value == '0);

  `KSMH_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken without going busy")
  `KSMH_ASSERT_NOW(a_res_busy, out_valid, busy, "result strobe while idle")
  `KSMH_ASSERT_NEXT(a_one_res, out_valid, !out_valid, "more than one result per request")
  `KSMH_ASSERT_NOW(a_zero_root, out_valid && !out_is_full, root_clear, "root shown while not full")
  `KSMH_ASSERT_NOW(a_fill_acc, out_valid && !out_is_full, out_accepted, "reject while not full")

endmodule

bind k_smallest_max_heap_unit ksmh_checker u_ksmh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_accepted  (out_accepted),
  .out_is_full   (out_is_full),
  .out_max_key   (out_max_key),
  .out_max_value (out_max_value)
);

// ===== dv/k_smallest_max_heap_unit_checker.sv =====
`timescale 1ns / 100ps

module k_smallest_max_heap_unit_checker import ksmh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_restart,
  input  logic [DATA_W-1:0] in_cand_key,
  input  logic [DATA_W-1:0] in_cand_value,
  input  logic              out_valid,
  input  logic              out_accepted,
  input  logic              out_is_full,
  input  logic [DATA_W-1:0] out_max_key,
  input  logic [DATA_W-1:0] out_max_value,
  input  logic              cfg_we,
  input  logic [K_W-1:0]    cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       rejected_count
);

  typedef struct packed {
    logic              accepted;
    logic              is_full;
    logic [DATA_W-1:0] max_key;
    logic [DATA_W-1:0] max_value;
  } heap_report_t;

  heap_report_t      reports_due[$];
  logic [DATA_W-1:0] heap_key[MAX_ENTRIES_DEF];
  logic [DATA_W-1:0] heap_val[MAX_ENTRIES_DEF];
  int unsigned       held;
  logic [K_W-1:0]    k_reg;

  initial begin
    fail_count     = 0;
    pending        = 0;
    rejected_count = 0;
    held           = 0;
    k_reg          = K_RESET;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [DATA_W-1:0] tk;
    logic [DATA_W-1:0] tv;
    tk = heap_key[a];
    tv = heap_val[a];
    heap_key[a] = heap_key[b];
    heap_val[a] = heap_val[b];
    heap_key[b] = tk;
    heap_val[b] = tv;
  endfunction

  function automatic void sink_entry(int unsigned pos, int unsigned n);
    int unsigned lc;
    int unsigned rc;
    int unsigned big;
    forever begin
      lc  = 2 * pos + 1;
      rc  = lc + 1;
      big = pos;
      if (lc < n && heap_key[lc] > heap_key[big]) big = lc;
      if (rc < n && heap_key[rc] > heap_key[big]) big = rc;
      if (big == pos) return;
      swap_slots(pos, big);
      pos = big;
    end
  endfunction

  function automatic heap_report_t predict_report(logic restart, logic [DATA_W-1:0] key,
                                                  logic [DATA_W-1:0] val);
    heap_report_t r;
    int unsigned  k_eff;
    k_eff = (k_reg == 0) ? 1 : ((k_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : k_reg);
    r.accepted = 1'b1;
    if (restart) held = 0;
    if (held > k_eff) held = 0;
    if (held < k_eff) begin
      heap_key[held] = key;
      heap_val[held] = val;
      held++;
      if (held == k_eff) begin
        for (int i = k_eff / 2; i > 0; i--) sink_entry(i - 1, k_eff);
      end
    end else if (key > heap_key[0]) begin
      r.accepted = 1'b0;
    end else begin
      heap_key[0] = key;
      heap_val[0] = val;
      sink_entry(0, k_eff);
    end
    r.is_full   = (held == k_eff);
    r.max_key   = r.is_full ? heap_key[0] : '0;
    r.max_value = r.is_full ? heap_val[0] : '0;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    heap_report_t want;
    if (!rst_n) begin
      reports_due.delete();
      held  = 0;
      k_reg = K_RESET;
    end else begin
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, got %0h %0h %0h %0h",
                   $time, out_accepted, out_is_full, out_max_key, out_max_value);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          compare_field("out_accepted", DATA_W'(want.accepted), DATA_W'(out_accepted));
          compare_field("out_is_full", DATA_W'(want.is_full), DATA_W'(out_is_full));
          compare_field("out_max_key", want.max_key, out_max_key);
          compare_field("out_max_value", want.max_value, out_max_value);
          if (!out_accepted) rejected_count++;
        end
      end
      if (cfg_we) begin
        k_reg = cfg_wdata;
        held  = 0;
      end
      if (start && !busy) begin
        reports_due = {reports_due, predict_report(in_restart, in_cand_key, in_cand_value)};
      end
    end
    pending = reports_due.size();
  end

endmodule

// ===== dv/k_smallest_max_heap_unit_tb.sv =====
`timescale 1ns / 100ps

module k_smallest_max_heap_unit_tb import ksmh_pkg::*;;

  localparam int STALL_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_restart = 1'b0;
  logic [DATA_W-1:0] in_cand_key = '0;
  logic [DATA_W-1:0] in_cand_value = '0;
  logic              out_valid;
  logic              out_accepted;
  logic              out_is_full;
  logic [DATA_W-1:0] out_max_key;
  logic [DATA_W-1:0] out_max_value;
  logic              cfg_we = 1'b0;
  logic [K_W-1:0]    cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned rejected_count;
  int unsigned stall_cycles = 0;
  int unsigned n_requests = 0;
  int unsigned n_restarts = 0;
  int unsigned n_settings = 0;
  int unsigned idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  k_smallest_max_heap_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_restart   (in_restart),
    .in_cand_key  (in_cand_key),
    .in_cand_value(in_cand_value),
    .out_valid    (out_valid),
    .out_accepted (out_accepted),
    .out_is_full  (out_is_full),
    .out_max_key  (out_max_key),
    .out_max_value(out_max_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  k_smallest_max_heap_unit_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_restart    (in_restart),
    .in_cand_key   (in_cand_key),
    .in_cand_value (in_cand_value),
    .out_valid     (out_valid),
    .out_accepted  (out_accepted),
    .out_is_full   (out_is_full),
    .out_max_key   (out_max_key),
    .out_max_value (out_max_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .rejected_count(rejected_count)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("k_smallest_max_heap_unit_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // hold start until the request is taken; idle_pct sets odds of dropping it
  task automatic send_request(logic restart, logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
    int unsigned gap;
    start         <= 1'b1;
    in_restart    <= restart;
    in_cand_key   <= key;
    in_cand_value <= val;
    do @(posedge clk); while (busy);
    n_requests++;
    if (restart) n_restarts++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_k(logic [K_W-1:0] k);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  initial begin
    logic [K_W-1:0] k_plan[16];
    int unsigned    phase;
    int unsigned    n_items;
    int unsigned    k_eff;

    k_plan = '{7'd2, 7'd64, 7'd5, 7'd127, 7'd1, 7'd9, 7'd3, 7'd33,
               7'd0, 7'd16, 7'd4, 7'd64, 7'd12, 7'd100, 7'd7, 7'd2};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // K at reset value, store not full
    send_request(1'b0, '0, '1);
    send_request(1'b0, '1, '0);
    send_request(1'b0, 32'h8000_0001, 32'h7FFF_FFFE);

    // zero acts as K of one: equal key replaces, larger rejects
    write_k('0);
    send_request(1'b0, 32'd5, 32'hA5A5_A5A5);
    send_request(1'b0, 32'd5, 32'h5A5A_5A5A);
    send_request(1'b0, 32'd6, 32'h1);
    send_request(1'b0, '0, 32'h2);
    send_request(1'b1, '1, 32'h3);
    send_request(1'b0, '1, 32'h4);

    // change K while partly filled, then fill a small heap with ties
    write_k(7'd3);
    send_request(1'b0, 32'd9, 32'd1);
    write_k(7'd4);
    send_request(1'b0, 32'd7, 32'd10);
    send_request(1'b0, 32'd7, 32'd11);
    send_request(1'b0, 32'd3, 32'd12);
    send_request(1'b0, 32'd7, 32'd13);
    send_request(1'b0, 32'd7, 32'd14);
    send_request(1'b0, 32'd8, 32'd15);
    send_request(1'b0, 32'd1, 32'd16);
    send_request(1'b1, 32'd2, 32'd17);
    send_request(1'b0, '1, 32'd18);

    phase = 0;
    while (n_requests < 750) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 65;
        default: idle_pct = 37;
      endcase
      write_k(k_plan[phase % 16]);
      k_eff = (k_plan[phase % 16] == 0) ? 1 :
              ((k_plan[phase % 16] > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : k_plan[phase % 16]);
      n_items = (k_eff >= 32) ? $urandom_range(90, 150) : $urandom_range(25, 60);
      for (int i = 0; i < n_items && n_requests < 750; i++) begin
        if (i == n_items / 2 && phase % 2 == 0) wait_for_results();
        send_request($urandom_range(24) == 0, pick_key(), $urandom);
      end
      phase++;
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("covered %0d requests under %0d K settings, %0d restarts, %0d rejected when full",
             n_requests, n_settings, n_restarts, rejected_count);
    if (fail_count == 0 && pending == 0) begin
      $display("k_smallest_max_heap_unit_tb: clean");
    end else begin
      $display("k_smallest_max_heap_unit_tb: errors");
    end
    $finish;
  end

endmodule
